@@ sv/smft_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// smft_pkg
// Shared types and constants of the sparse matrix fast transpose block.
// ============================================================================
package smft_pkg;

    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd1;
    localparam logic [CFG_W-1:0]     NUM_COLS_RST = 7'd64;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } term_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_PREFIX,
        ST_PLACE,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic load;
        logic prefix;
        logic place;
        logic out_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic prefix_done;
        logic place_done;
        logic out_accept;
        logic out_last;
    } status_t;

endpackage

@@ sv/smft_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// smft_ctrl
// Phase sequencer: load, prefix sum, placement, emission and clear.
// ============================================================================
module smft_ctrl
    import smft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    is_last,
    output logic    in_ready,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && is_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = status.n_zero ? ST_CLEAR : ST_PREFIX;
            end
            ST_PREFIX:
            begin
                if (status.prefix_done)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                if (status.place_done)
                begin
                    state_next = ST_EMIT_LOAD;
                end
            end
            ST_EMIT_LOAD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (status.out_accept)
                begin
                    state_next = status.out_last ? ST_CLEAR : ST_EMIT_LOAD;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_LOAD);
        cmd.load     = (state_reg == ST_LOAD) && in_valid;
        cmd.prefix   = (state_reg == ST_PREFIX);
        cmd.place    = (state_reg == ST_PLACE);
        cmd.out_load = (state_reg == ST_EMIT_LOAD);
        cmd.clear    = (state_reg == ST_CLEAR);
    end

endmodule

@@ sv/smft_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// smft_dp
// Term, count, start slot and result stores with their sweep pipelines.
// ============================================================================
module smft_dp
    import smft_pkg::*;
#(
    parameter int MAX_TERMS = 64,
    parameter int MAX_DIM   = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [CFG_W-1:0]        num_cols,
    input  logic [ROW_W-1:0]        term_row,
    input  logic [COL_W-1:0]        term_col,
    input  logic signed [VAL_W-1:0] term_value,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [ROW_W-1:0]        out_row,
    output logic [COL_W-1:0]        out_col,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    out_last
);

    localparam int TW  = $clog2(MAX_TERMS + 1);
    localparam int TAW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DAW = $clog2(MAX_DIM);
    localparam int DIW = $clog2(MAX_DIM + 1);

    term_t           term_mem  [MAX_TERMS];
    term_t           res_mem   [MAX_TERMS];
    logic [TW-1:0]   cnt_mem   [MAX_DIM];
    logic [TW-1:0]   start_mem [MAX_DIM];

    logic [MAX_DIM-1:0] cnt_vld_reg;

    logic [TW-1:0]   loaded_reg;
    logic [DIW-1:0]  pre_idx_reg;
    logic [TW-1:0]   run_reg;
    logic [TW-1:0]   pl_idx_reg;
    logic [TW-1:0]   em_idx_reg;
    logic [TW-1:0]   em_idx_next;

    logic            s1_vld_reg;
    logic [DAW-1:0]  s1_addr_reg;
    logic [TW-1:0]   cnt_rd_reg;
    logic            cnt_rvld_reg;
    logic            lw_vld_reg;
    logic [DAW-1:0]  lw_addr_reg;
    logic [TW-1:0]   lw_data_reg;

    logic            p1_vld_reg;
    logic [DAW-1:0]  p1_addr_reg;

    logic            q1_vld_reg;
    term_t           term_rd_reg;
    logic            q2_vld_reg;
    term_t           q2_term_reg;
    logic [DAW-1:0]  q2_addr_reg;
    logic [TW-1:0]   start_rd_reg;
    logic            slw_vld_reg;
    logic [DAW-1:0]  slw_addr_reg;
    logic [TW-1:0]   slw_data_reg;

    term_t           res_rd_reg;
    logic            out_valid_reg;
    term_t           out_term_reg;
    logic            out_last_reg;

    logic [DAW-1:0]  col_addr;
    logic            col_ok;
    logic            keep;
    term_t           wr_term;
    logic [DAW-1:0]  cnt_raddr;
    logic [TW-1:0]   cnt_base;
    logic [TW-1:0]   cnt_new;
    logic [TW-1:0]   cnt_val;
    logic            pre_issue;
    logic            pl_issue;
    logic [DAW-1:0]  st_raddr;
    logic [TW-1:0]   slot;
    logic [TW-1:0]   slot_inc;
    logic            st_we;
    logic [DAW-1:0]  st_waddr;
    logic [TW-1:0]   st_wdata;
    term_t           res_wr;
    logic            out_acc;

    // Load path
    always_comb
    begin
        col_addr      = DAW'(term_col);
        col_ok        = ({1'b0, term_col} < num_cols) && (32'(term_col) < MAX_DIM);
        keep          = cmd.load && col_ok && (loaded_reg < TW'(MAX_TERMS));
        wr_term.row   = term_row;
        wr_term.col   = term_col;
        wr_term.value = term_value;
        cnt_raddr     = cmd.prefix ? pre_idx_reg[DAW-1:0] : col_addr;
        cnt_base      = (lw_vld_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg :
                        (cnt_rvld_reg ? cnt_rd_reg : '0);
        cnt_new       = cnt_base + TW'(1);
        cnt_val       = cnt_rvld_reg ? cnt_rd_reg : '0;
    end

    // Prefix and placement paths
    always_comb
    begin
        pre_issue = cmd.prefix && (pre_idx_reg < DIW'(MAX_DIM));
        pl_issue  = cmd.place && (pl_idx_reg < loaded_reg);
        st_raddr  = DAW'(term_rd_reg.col);
        slot      = (slw_vld_reg && (slw_addr_reg == q2_addr_reg)) ? slw_data_reg
                                                                 : start_rd_reg;
        slot_inc  = slot + TW'(1);
        st_we     = p1_vld_reg || q2_vld_reg;
        st_waddr  = p1_vld_reg ? p1_addr_reg : q2_addr_reg;
        st_wdata  = p1_vld_reg ? run_reg : slot_inc;
        res_wr.row   = ROW_W'(q2_addr_reg);
        res_wr.col   = q2_term_reg.row;
        res_wr.value = q2_term_reg.value;
    end

    // Emission path
    always_comb
    begin
        out_acc     = out_valid_reg && out_ready;
        em_idx_next = out_acc ? (em_idx_reg + TW'(1)) : em_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            term_mem[loaded_reg[TAW-1:0]] <= wr_term;
        end
        term_rd_reg <= term_mem[pl_idx_reg[TAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            cnt_mem[s1_addr_reg] <= cnt_new;
        end
        cnt_rd_reg   <= cnt_mem[cnt_raddr];
        cnt_rvld_reg <= cnt_vld_reg[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            start_mem[st_waddr] <= st_wdata;
        end
        start_rd_reg <= start_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q2_vld_reg)
        begin
            res_mem[slot[TAW-1:0]] <= res_wr;
        end
        res_rd_reg <= res_mem[em_idx_next[TAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= col_addr;
        p1_addr_reg <= pre_idx_reg[DAW-1:0];
        q2_term_reg <= term_rd_reg;
        q2_addr_reg <= st_raddr;
        if (cmd.out_load)
        begin
            out_term_reg <= res_rd_reg;
            out_last_reg <= ((em_idx_reg + TW'(1)) == loaded_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            pre_idx_reg   <= '0;
            run_reg       <= '0;
            pl_idx_reg    <= '0;
            em_idx_reg    <= '0;
            cnt_vld_reg   <= '0;
            s1_vld_reg    <= 1'b0;
            lw_vld_reg    <= 1'b0;
            lw_addr_reg   <= '0;
            lw_data_reg   <= '0;
            p1_vld_reg    <= 1'b0;
            q1_vld_reg    <= 1'b0;
            q2_vld_reg    <= 1'b0;
            slw_vld_reg   <= 1'b0;
            slw_addr_reg  <= '0;
            slw_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= keep;
            p1_vld_reg <= pre_issue;
            q1_vld_reg <= pl_issue;
            q2_vld_reg <= q1_vld_reg;

            if (cmd.clear)
            begin
                loaded_reg  <= '0;
                pre_idx_reg <= '0;
                run_reg     <= '0;
                pl_idx_reg  <= '0;
                em_idx_reg  <= '0;
                cnt_vld_reg <= '0;
                lw_vld_reg  <= 1'b0;
                slw_vld_reg <= 1'b0;
            end
            else
            begin
                em_idx_reg <= em_idx_next;
                if (keep)
                begin
                    loaded_reg <= loaded_reg + TW'(1);
                end
                if (s1_vld_reg)
                begin
                    cnt_vld_reg[s1_addr_reg] <= 1'b1;
                    lw_vld_reg               <= 1'b1;
                    lw_addr_reg              <= s1_addr_reg;
                    lw_data_reg              <= cnt_new;
                end
                if (pre_issue)
                begin
                    pre_idx_reg <= pre_idx_reg + DIW'(1);
                end
                if (p1_vld_reg)
                begin
                    run_reg <= run_reg + cnt_val;
                end
                if (pl_issue)
                begin
                    pl_idx_reg <= pl_idx_reg + TW'(1);
                end
                if (q2_vld_reg)
                begin
                    slw_vld_reg  <= 1'b1;
                    slw_addr_reg <= q2_addr_reg;
                    slw_data_reg <= slot_inc;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.n_zero      = (loaded_reg == '0);
        status.prefix_done = !(pre_idx_reg < DIW'(MAX_DIM)) && !p1_vld_reg;
        status.place_done  = !(pl_idx_reg < loaded_reg) && !q1_vld_reg && !q2_vld_reg;
        status.out_accept  = out_acc;
        status.out_last    = out_last_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_term_reg.row;
    assign out_col   = out_term_reg.col;
    assign out_value = out_term_reg.value;
    assign out_last  = out_last_reg;

endmodule

@@ sv/sparse_matrix_fast_transpose.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sparse_matrix_fast_transpose
// Transposes a sparse matrix given as a stream of (row, column, value) terms.
// ============================================================================
// Usage:
//   Terms enter on the in_valid/in_ready channel, one transaction per cycle,
//   while the block is loading. A term whose column is not below num_cols,
//   or that arrives after MAX_TERMS terms are held, is dropped; its is_last
//   flag still ends the matrix. After the last term in_ready drops while
//   the block runs: a flush state, a prefix sweep over the column count
//   store, and a placement sweep over the n held terms. The transposed
//   terms then leave on out_valid/out_ready grouped by row, the terms of
//   one row in arrival order, each passing through the result store read
//   register and the output register, with out_last on the final one. A
//   stalled receiver holds the output register and the sequence. A clear
//   state follows, then loading resumes. An empty matrix goes from the
//   flush state straight to the clear state. Reset empties all stores and
//   sets num_cols to 64; the row count is not stored. The config channel
//   always accepts; write it only while the block is idle.
// ============================================================================
module sparse_matrix_fast_transpose
    import smft_pkg::*;
#(
    parameter int MAX_TERMS = 64,
    parameter int MAX_DIM   = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ROW_W-1:0]        term_row,
    input  logic [COL_W-1:0]        term_col,
    input  logic signed [VAL_W-1:0] term_value,
    input  logic                    is_last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ROW_W-1:0]        out_row,
    output logic [COL_W-1:0]        out_col,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    out_last
);

    logic [CFG_W-1:0] num_cols_reg;
    cmd_t             cmd;
    status_t          status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NUM_COLS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_COLS:
                begin
                    num_cols_reg <= cfg_data;
                end
                CFG_NUM_ROWS:
                begin
                    // row count has no effect on the transpose; drop it
                end
                default:
                begin
                end
            endcase
        end
    end

    smft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_last  (is_last),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    smft_dp #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_DIM   (MAX_DIM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .num_cols   (num_cols_reg),
        .term_row   (term_row),
        .term_col   (term_col),
        .term_value (term_value),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .out_last   (out_last)
    );

endmodule

@@ test/sparse_matrix_fast_transpose_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sparse_matrix_fast_transpose_tb
// Self-checking bench for the sparse matrix fast transpose block. Matrices go
// in as term streams with random gaps. The bench mirrors the column-stable
// transpose at every matrix end. Each emitted term is checked in order
// against that mirror while the receiver stalls at random.
// ============================================================================
module sparse_matrix_fast_transpose_tb;
    import smft_pkg::*;

    localparam int MAX_TERMS    = 64;
    localparam int MAX_DIM      = 64;
    localparam int RANDOM_TERMS = 400;
    localparam int SETTLE       = 2 * MAX_DIM + 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } transposed_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_NUM_COLS;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [ROW_W-1:0]        term_row = '0;
    logic [COL_W-1:0]        term_col = '0;
    logic signed [VAL_W-1:0] term_value = '0;
    logic                    is_last = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;

    term_t       held_terms[$];
    transposed_t transposed_q[$];
    logic [CFG_W-1:0] col_limit = NUM_COLS_RST;
    logic [CFG_W-1:0] row_count = 7'd64;
    logic        quiet_mode = 1'b0;
    int          stall_left = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    sparse_matrix_fast_transpose #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_DIM   (MAX_DIM)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .term_row   (term_row),
        .term_col   (term_col),
        .term_value (term_value),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .out_last   (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (quiet_mode || r < 6)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic term_t make_term(input int row, input int col, input logic [31:0] value);
        term_t t;
        t.row   = row[ROW_W-1:0];
        t.col   = col[COL_W-1:0];
        t.value = value;
        return t;
    endfunction

    function automatic term_t random_term(input int col_bound);
        return make_term($urandom_range(0, MAX_DIM - 1), $urandom_range(0, col_bound - 1),
                         $urandom);
    endfunction

    // Keep the term if its column fits and the store has room; on the last one, emit a column-stable transpose.
    task automatic record_term(input term_t t, input logic last);
        transposed_t r;
        int remaining;
        if (t.col < col_limit && held_terms.size() < MAX_TERMS)
            held_terms.push_back(t);
        if (last)
        begin
            remaining = held_terms.size();
            for (int c = 0; c < MAX_DIM; c++)
            begin
                foreach (held_terms[i])
                begin
                    if (held_terms[i].col == c)
                    begin
                        remaining--;
                        r.row   = held_terms[i].col;
                        r.col   = held_terms[i].row;
                        r.value = held_terms[i].value;
                        r.last  = (remaining == 0);
                        transposed_q.push_back(r);
                    end
                end
            end
            held_terms.delete();
        end
    endtask

    task automatic send_term(input term_t t, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        term_row   <= t.row;
        term_col   <= t.col;
        term_value <= t.value;
        is_last    <= last;
        do @(posedge clk); while (!in_ready);
        record_term(t, last);
    endtask

    task automatic send_matrix(input term_t terms[$]);
        foreach (terms[i])
            send_term(terms[i], i == terms.size() - 1);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        while (transposed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NUM_COLS;
        cfg_data  <= cols;
        do @(posedge clk); while (!cfg_ready);
        col_limit = cols;
        cfg_index <= CFG_NUM_ROWS;
        cfg_data  <= rows;
        do @(posedge clk); while (!cfg_ready);
        row_count = rows;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_field_extremes();
        term_t terms[$];
        terms.push_back(make_term(0, 0, 32'h8000_0000));
        terms.push_back(make_term(63, 63, 32'h7FFF_FFFF));
        terms.push_back(make_term(0, 63, 32'h0000_0000));
        terms.push_back(make_term(63, 0, 32'hFFFF_FFFF));
        terms.push_back(make_term(21, 42, 32'h5555_5555));
        terms.push_back(make_term(42, 21, 32'hAAAA_AAAA));
        send_matrix(terms);
    endtask

    task automatic test_column_filter();
        term_t terms[$];
        write_config(7'd1, 7'd1);
        terms.push_back(make_term(5, 0, 32'h0000_0011));
        terms.push_back(make_term(7, 1, 32'h0000_0022));
        terms.push_back(make_term(9, 63, 32'h0000_0033));
        terms.push_back(make_term(3, 0, 32'h0000_0044));
        // last flag on a dropped term still closes the matrix
        terms.push_back(make_term(11, 40, 32'h0000_0055));
        send_matrix(terms);
        write_config(7'd33, 7'd64);
        terms.delete();
        terms.push_back(make_term(1, 32, 32'h1234_5678));
        terms.push_back(make_term(2, 33, 32'h8765_4321));
        terms.push_back(make_term(3, 31, 32'hDEAD_BEEF));
        terms.push_back(make_term(4, 32, 32'h0BAD_F00D));
        send_matrix(terms);
    endtask

    task automatic test_empty_matrix();
        term_t terms[$];
        terms.push_back(make_term(6, 50, 32'hCAFE_0001));
        send_matrix(terms);
        wait_for_drain();
        terms.delete();
        terms.push_back(make_term(8, 12, 32'hCAFE_0002));
        send_matrix(terms);
        wait_for_drain();
    endtask

    task automatic test_arrival_order();
        term_t terms[$];
        write_config(7'd64, 7'd64);
        terms.push_back(make_term(40, 17, 32'h0000_0001));
        terms.push_back(make_term(2, 17, 32'h0000_0002));
        terms.push_back(make_term(30, 3, 32'h0000_0003));
        terms.push_back(make_term(2, 17, 32'h0000_0004));
        terms.push_back(make_term(0, 17, 32'h0000_0005));
        send_matrix(terms);
    endtask

    task automatic test_store_full();
        term_t terms[$];
        for (int i = 0; i < MAX_TERMS + 6; i++)
            terms.push_back(random_term(MAX_DIM));
        send_matrix(terms);
    endtask

    task automatic test_random_matrices();
        term_t terms[$];
        term_t t;
        int kept;
        int stored;
        int size;
        int pick;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
        kept = 0;
        while (kept < RANDOM_TERMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, 3);
                cols = (pick == 0) ? 7'd1 : (pick == 1) ? 7'd64 :
                       CFG_W'($urandom_range(1, MAX_DIM));
                rows = $urandom_range(0, 1) ? 7'd64 : CFG_W'($urandom_range(1, MAX_DIM));
                write_config(cols, rows);
            end
            else if ($urandom_range(0, 5) == 0)
                wait_for_drain();
            quiet_mode = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 15)
                size = $urandom_range(1, 16);
            else if (pick < 19)
                size = $urandom_range(17, MAX_TERMS);
            else
                size = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 8);
            terms.delete();
            stored = 0;
            for (int i = 0; i < size; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    t = random_term(MAX_DIM);
                else
                    t = random_term(int'(col_limit));
                if (t.col < col_limit && stored < MAX_TERMS)
                    stored++;
                terms.push_back(t);
            end
            send_matrix(terms);
            kept += stored;
        end
        quiet_mode = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap();
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        transposed_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (transposed_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected term: row %0d col %0d value %0d last %0b",
                             out_row, out_col, out_value, out_last);
            end
            else
            begin
                want = transposed_q.pop_front();
                if (out_row !== want.row || out_col !== want.col ||
                    out_value !== want.value || out_last !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: expected row %0d col %0d value %0d last %0b,",
                                  " got row %0d col %0d value %0d last %0b"},
                                 want.row, want.col, want.value, want.last,
                                 out_row, out_col, out_value, out_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_column_filter();
        test_empty_matrix();
        test_arrival_order();
        test_store_full();
        test_random_matrices();
        wait_for_drain();
        if (error_count == 0 && transposed_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
